### hw/rtl/dles_pkg.sv
package dles_pkg;

   localparam int unsigned ACTION_W   = 3;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned POSITION_W = 6;
   localparam int unsigned RDATA_W    = 32;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned STATUS_W   = 2;

   localparam int unsigned REQ_BITS   = ACTION_W + VALUE_W + POSITION_W;
   localparam int unsigned REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS   = RDATA_W + COUNT_W + STATUS_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_ADD_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_POP_FRONT,
      CELL_WRITE,
      CELL_SCAN_LOAD,
      CELL_SCAN_SHIFT
   } cell_op_type;

endpackage

### hw/rtl/dles_cell.sv
module dles_cell #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned IDX_W      = 6,
   parameter int unsigned INDEX      = 0
) (
   input  logic                    clock,
   input  dles_pkg::cell_op_type   op,
   input  logic [IDX_W-1:0]        wr_index,
   input  logic [DATA_WIDTH-1:0]   new_word,
   input  logic [DATA_WIDTH-1:0]   prev_word,
   input  logic [DATA_WIDTH-1:0]   next_word,
   input  logic [DATA_WIDTH-1:0]   next_scan,
   output logic [DATA_WIDTH-1:0]   data_out,
   output logic [DATA_WIDTH-1:0]   scan_out
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] scan_ff, scan_in;

   always_comb begin
      data_in = data_ff;
      scan_in = scan_ff;
      case (op)
         dles_pkg::CELL_PUSH_FRONT: data_in = prev_word;
         dles_pkg::CELL_POP_FRONT:  data_in = next_word;
         dles_pkg::CELL_WRITE: begin
            if (wr_index == IDX_W'(INDEX)) begin
               data_in = new_word;
            end
         end
         dles_pkg::CELL_SCAN_LOAD:  scan_in = data_ff;
         dles_pkg::CELL_SCAN_SHIFT: scan_in = next_scan;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      scan_ff <= scan_in;
   end

   assign data_out = data_ff;
   assign scan_out = scan_ff;

endmodule

### hw/rtl/double_ended_list_store.sv
// Bounded double-ended list of DATA_WIDTH-bit signed words held in a row of
// DEPTH cells, cell 0 being the front. Each request carries one action (add
// front, add back, remove front, remove back, read at a position from the
// front) and returns exactly one response with the read word (sign extended,
// zero unless a good read), the entry count after the action and a status
// (ok, full, empty, position out of range). A failing action changes nothing.
// Front adds and removes shift the row by one cell in the accept cycle; a
// back add fills the next free cell and a back remove only lowers the count.
// A good read at position p shifts a scan copy of the row frontward one cell
// per cycle p times, then puts cell 0 in the response register, which
// decouples the two sides; requests are taken when the block is idle and the
// response register is free or draining. The list is empty after reset.
module double_ended_list_store #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] action, [34:3] value, [40:35] position, upper bits zero
   input  logic [dles_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] read_data, [38:32] count, [40:39] status, upper bits zero
   output logic [dles_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > dles_pkg::POSITION_W) ? CNT_W
                                                                 : dles_pkg::POSITION_W;

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type                            state_ff, state_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic [dles_pkg::POSITION_W-1:0]      scan_left_ff, scan_left_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [dles_pkg::RDATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [dles_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [dles_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   logic [dles_pkg::ACTION_W-1:0]        req_action;
   logic [dles_pkg::VALUE_W-1:0]         req_value;
   logic [dles_pkg::POSITION_W-1:0]      req_position;
   logic [DATA_WIDTH-1:0]                new_word;
   logic                                 req_take, out_free, load_rsp;
   logic                                 is_full, is_empty;
   logic [dles_pkg::RDATA_W-1:0]         scan_ext;
   dles_pkg::cell_op_type                cell_op;

   logic [DATA_WIDTH-1:0]                cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]                cell_scan [DEPTH];

   assign req_action   = req_tdata[2:0];
   assign req_value    = req_tdata[34:3];
   assign req_position = req_tdata[40:35];

   assign new_word = DATA_WIDTH'(req_value);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_take = req_tvalid && req_tready;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign scan_ext = dles_pkg::RDATA_W'(signed'(cell_scan[0]));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_left_in  = scan_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      load_rsp      = 1'b0;
      cell_op       = dles_pkg::CELL_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               load_rsp      = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = dles_pkg::STAT_OK;
               case (req_action)
                  dles_pkg::ACT_ADD_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = dles_pkg::STAT_FULL;
                     end else begin
                        cell_op  = dles_pkg::CELL_PUSH_FRONT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dles_pkg::ACT_ADD_BACK: begin
                     if (is_full) begin
                        rsp_status_in = dles_pkg::STAT_FULL;
                     end else begin
                        cell_op  = dles_pkg::CELL_WRITE;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dles_pkg::ACT_REM_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = dles_pkg::STAT_EMPTY;
                     end else begin
                        cell_op  = dles_pkg::CELL_POP_FRONT;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dles_pkg::ACT_REM_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = dles_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dles_pkg::ACT_READ: begin
                     if (CMP_W'(req_position) >= CMP_W'(count_ff)) begin
                        rsp_status_in = dles_pkg::STAT_RANGE;
                     end else begin
                        load_rsp     = 1'b0;
                        cell_op      = dles_pkg::CELL_SCAN_LOAD;
                        scan_left_in = req_position;
                        state_in     = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_left_ff != '0) begin
               cell_op      = dles_pkg::CELL_SCAN_SHIFT;
               scan_left_in = scan_left_ff - 1'b1;
            end else if (out_free) begin
               load_rsp      = 1'b1;
               rsp_data_in   = scan_ext;
               rsp_status_in = dles_pkg::STAT_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = dles_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_left_ff  <= scan_left_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_word, next_word, next_scan;
      if (i == 0) begin : g_first
         assign prev_word = new_word;
      end else begin : g_mid
         assign prev_word = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_word = '0;
         assign next_scan = '0;
      end else begin : g_inner
         assign next_word = cell_data[i+1];
         assign next_scan = cell_scan[i+1];
      end
      dles_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .wr_index  (count_ff[IDX_W-1:0]),
         .new_word  (new_word),
         .prev_word (prev_word),
         .next_word (next_word),
         .next_scan (next_scan),
         .data_out  (cell_data[i]),
         .scan_out  (cell_scan[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dles_pkg::RSP_TDATA_W'({rsp_status_ff, rsp_count_ff, rsp_data_ff});

endmodule
